// ===== design/phfe_pkg.sv =====
// Package for the packet header flow extractor.
// Parse phases, header lengths and the flow key record; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package phfe_pkg;

  typedef enum logic [3:0] {
    PH_ETH   = 4'd0,
    PH_LLC   = 4'd1,
    PH_SNAP  = 4'd2,
    PH_VLAN1 = 4'd3,
    PH_VSKIP = 4'd4,
    PH_MPLS  = 4'd5,
    PH_ARP   = 4'd6,
    PH_IP    = 4'd7,
    PH_L4    = 4'd8
  } phase_t;

  localparam int CapMax = 28;

  localparam logic [4:0] LenEth  = 5'd14;
  localparam logic [4:0] LenLlc  = 5'd3;
  localparam logic [4:0] LenSnap = 5'd5;
  localparam logic [4:0] LenVlan = 5'd4;
  localparam logic [4:0] LenMpls = 5'd4;
  localparam logic [4:0] LenArp  = 5'd28;
  localparam logic [4:0] LenIp   = 5'd20;
  localparam logic [4:0] LenTcp  = 5'd20;
  localparam logic [4:0] LenUdp  = 5'd8;
  localparam logic [4:0] LenIcmp = 5'd4;
  localparam logic [4:0] LenSctp = 5'd12;

  localparam logic [15:0] TypeVlan  = 16'h8100;
  localparam logic [15:0] TypeQinq  = 16'h88A8;
  localparam logic [15:0] TypeMplsU = 16'h8847;
  localparam logic [15:0] TypeMplsM = 16'h8848;
  localparam logic [15:0] TypeArp   = 16'h0806;
  localparam logic [15:0] TypeIpv4  = 16'h0800;

  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [7:0] ProtoTcp  = 8'd6;
  localparam logic [7:0] ProtoUdp  = 8'd17;
  localparam logic [7:0] ProtoSctp = 8'd132;

  // Where to go after the layer 2 ethertype is known
  typedef struct packed {
    phase_t     ph;
    logic [4:0] len;
    logic       stop;
  } route_t;

  typedef struct packed {
    logic [31:0] port;
    logic [47:0] dst;
    logic [47:0] src;
    logic [15:0] etype;
    logic [15:0] vid;
    logic [2:0]  pcp;
    logic [2:0]  tc;
    logic [19:0] label;
    logic [7:0]  proto;
    logic [5:0]  tos;
    logic [31:0] nsrc;
    logic [31:0] ndst;
    logic [15:0] tpsrc;
    logic [15:0] tpdst;
    logic [10:0] present;
  } key_t;

  function automatic logic is_vlan(input logic [15:0] t);
    return (t == TypeVlan) || (t == TypeQinq);
  endfunction

  function automatic route_t route_f(input logic [15:0] t);
    route_t r;
    r.ph   = PH_ETH;
    r.len  = LenEth;
    r.stop = 1'b0;
    if ((t == TypeMplsU) || (t == TypeMplsM)) begin
      r.ph  = PH_MPLS;
      r.len = LenMpls;
    end else if (t == TypeArp) begin
      r.ph  = PH_ARP;
      r.len = LenArp;
    end else if (t == TypeIpv4) begin
      r.ph  = PH_IP;
      r.len = LenIp;
    end else begin
      r.stop = 1'b1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/packet_header_flow_extractor_unit.sv =====
// Byte-serial flow key extractor, top level.
// Depends on phfe_pkg for phases, lengths and the key record.
// Latency: the key is shown in the cycle after the last byte's transfer.
// Throughput: one byte per cycle; a byte is taken while a key waits, unless
// a last byte would need the occupied result register.
// Reset (rst, synchronous): parser at start of Ethernet header, no frame
// open, result register empty.
`timescale 1ns / 1ps
`default_nettype none
module packet_header_flow_extractor_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [7:0]  pkt_byte,
  input  wire logic [31:0] in_port,
  input  wire logic        last_byte,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [31:0] port_out,
  output      logic [47:0] eth_dst,
  output      logic [47:0] eth_src,
  output      logic [15:0] ether_type,
  output      logic [18:0] vlan_word,
  output      logic [22:0] mpls_word,
  output      logic [31:0] ip_src,
  output      logic [31:0] ip_dst,
  output      logic [13:0] proto_tos,
  output      logic [31:0] l4_ports,
  output      logic [10:0] present_bits
);

  // Parser state
  phfe_pkg::phase_t phase, phase_next;
  logic [4:0]       count, count_next;
  logic [4:0]       need, need_next;
  logic             done, done_next;
  logic             frame_open;
  logic [7:0]       cap [phfe_pkg::CapMax];
  logic [7:0]       cap_next [phfe_pkg::CapMax];
  logic [95:0]      macs, macs_next;
  phfe_pkg::key_t   key, key_next;

  logic             in_fire;
  phfe_pkg::route_t rt;
  logic [15:0]      t16;

  assign in_ready = !out_valid || out_ready || !last_byte;
  assign in_fire  = in_valid && in_ready;

  // Next-state for one byte
  always_comb begin
    phfe_pkg::phase_t ph_b;
    logic [4:0]       cnt_b;
    logic [4:0]       need_b;
    logic             done_b;
    logic [95:0]      macs_b;
    phfe_pkg::key_t   k;
    ph_b   = phase;
    cnt_b  = count;
    need_b = need;
    done_b = done;
    macs_b = macs;
    k      = key;
    rt     = '0;
    t16    = '0;
    if (!frame_open) begin
      ph_b   = phfe_pkg::PH_ETH;
      cnt_b  = '0;
      need_b = phfe_pkg::LenEth;
      done_b = 1'b0;
      macs_b = '0;
      k      = '0;
      k.port = in_port;
    end
    for (int i = 0; i < phfe_pkg::CapMax; i++) begin
      cap_next[i] = cap[i];
    end
    if (!done_b && (cnt_b < need_b) && (cnt_b < 5'(phfe_pkg::CapMax))) begin
      for (int i = 0; i < phfe_pkg::CapMax; i++) begin
        if (cnt_b == 5'(i)) cap_next[i] = pkt_byte;
      end
      cnt_b = cnt_b + 5'd1;
      if (cnt_b == need_b) begin
        case (ph_b)
          phfe_pkg::PH_ETH, phfe_pkg::PH_SNAP: begin
            logic ok;
            logic [47:0] d, s;
            if (ph_b == phfe_pkg::PH_ETH) begin
              t16 = {cap_next[12], cap_next[13]};
              d = {cap_next[0], cap_next[1], cap_next[2], cap_next[3], cap_next[4],
                   cap_next[5]};
              s = {cap_next[6], cap_next[7], cap_next[8], cap_next[9], cap_next[10],
                   cap_next[11]};
              ok = (t16 >= 16'h0600);
            end else begin
              t16 = {cap_next[3], cap_next[4]};
              d = macs_b[95:48];
              s = macs_b[47:0];
              ok = (cap_next[0] == 8'h00) && (cap_next[1] == 8'h00) &&
                   (cap_next[2] == 8'h00);
            end
            if (ok) begin
              k.dst     = d;
              k.src     = s;
              k.etype   = t16;
              k.present = k.present | 11'h201;
              if (phfe_pkg::is_vlan(t16)) begin
                k.present = k.present | 11'h006;
                ph_b   = phfe_pkg::PH_VLAN1;
                need_b = phfe_pkg::LenVlan;
                cnt_b  = '0;
              end else begin
                k.vid = 16'hFFFF;
                rt = phfe_pkg::route_f(t16);
                if (rt.stop) done_b = 1'b1;
                else begin
                  ph_b = rt.ph; need_b = rt.len; cnt_b = '0;
                end
              end
            end else if (ph_b == phfe_pkg::PH_ETH) begin
              macs_b = {d, s};
              ph_b   = phfe_pkg::PH_LLC;
              need_b = phfe_pkg::LenLlc;
              cnt_b  = '0;
            end else begin
              done_b = 1'b1;
            end
          end
          phfe_pkg::PH_LLC: begin
            if ((cap_next[0] == 8'hAA) && (cap_next[1] == 8'hAA) && (cap_next[2] == 8'h03))
            begin
              ph_b = phfe_pkg::PH_SNAP; need_b = phfe_pkg::LenSnap; cnt_b = '0;
            end else begin
              done_b = 1'b1;
            end
          end
          phfe_pkg::PH_VLAN1, phfe_pkg::PH_VSKIP: begin
            if (ph_b == phfe_pkg::PH_VLAN1) begin
              k.vid = {4'h0, cap_next[0][3:0], cap_next[1]};
              k.pcp = cap_next[0][7:5];
            end
            k.etype = {cap_next[2], cap_next[3]};
            if (phfe_pkg::is_vlan(k.etype)) begin
              ph_b = phfe_pkg::PH_VSKIP; need_b = phfe_pkg::LenVlan; cnt_b = '0;
            end else begin
              rt = phfe_pkg::route_f(k.etype);
              if (rt.stop) done_b = 1'b1;
              else begin
                ph_b = rt.ph; need_b = rt.len; cnt_b = '0;
              end
            end
          end
          phfe_pkg::PH_MPLS: begin
            k.label   = {cap_next[0], cap_next[1], cap_next[2][7:4]};
            k.tc      = cap_next[2][3:1];
            k.present = k.present | 11'h018;
            done_b    = 1'b1;
          end
          phfe_pkg::PH_ARP: begin
            if (({cap_next[0], cap_next[1]} == 16'h0001) &&
                ({cap_next[2], cap_next[3]} == phfe_pkg::TypeIpv4) &&
                (cap_next[4] == 8'd6) && (cap_next[5] == 8'd4)) begin
              if (cap_next[6] == 8'h00) begin
                k.present = k.present | 11'h020;
                k.proto   = cap_next[7];
              end
              if ((k.proto == 8'd1) || (k.proto == 8'd2)) begin
                k.present = k.present | 11'h400;
                k.nsrc = {cap_next[14], cap_next[15], cap_next[16], cap_next[17]};
                k.ndst = {cap_next[24], cap_next[25], cap_next[26], cap_next[27]};
              end
            end
            done_b = 1'b1;
          end
          phfe_pkg::PH_IP: begin
            k.present = k.present | 11'h460;
            k.nsrc  = {cap_next[12], cap_next[13], cap_next[14], cap_next[15]};
            k.ndst  = {cap_next[16], cap_next[17], cap_next[18], cap_next[19]};
            k.tos   = cap_next[1][7:2];
            k.proto = cap_next[9];
            if ({cap_next[6][5:0], cap_next[7]} != 14'd0) begin
              done_b = 1'b1;
            end else begin
              cnt_b = '0;
              ph_b  = phfe_pkg::PH_L4;
              case (k.proto)
                phfe_pkg::ProtoTcp:  need_b = phfe_pkg::LenTcp;
                phfe_pkg::ProtoUdp:  need_b = phfe_pkg::LenUdp;
                phfe_pkg::ProtoIcmp: need_b = phfe_pkg::LenIcmp;
                phfe_pkg::ProtoSctp: need_b = phfe_pkg::LenSctp;
                default: begin
                  ph_b   = phfe_pkg::PH_IP;
                  done_b = 1'b1;
                end
              endcase
            end
          end
          default: begin
            // Layer 4: ICMP keeps type and code as single bytes
            if (k.proto == phfe_pkg::ProtoIcmp) begin
              k.tpsrc = {8'h00, cap_next[0]};
              k.tpdst = {8'h00, cap_next[1]};
            end else begin
              k.tpsrc = {cap_next[0], cap_next[1]};
              k.tpdst = {cap_next[2], cap_next[3]};
            end
            k.present = k.present | 11'h180;
            done_b    = 1'b1;
          end
        endcase
      end
    end
    phase_next = ph_b;
    count_next = cnt_b;
    need_next  = need_b;
    done_next  = done_b;
    macs_next  = macs_b;
    key_next   = k;
  end

  // Parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= phfe_pkg::PH_ETH;
      count      <= '0;
      need       <= phfe_pkg::LenEth;
      done       <= 1'b0;
      frame_open <= 1'b0;
    end else if (in_fire) begin
      phase      <= phase_next;
      count      <= count_next;
      need       <= need_next;
      done       <= done_next;
      frame_open <= !last_byte;
    end
  end

  // Capture bytes, pending MACs and key: payload only
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < phfe_pkg::CapMax; i++) begin
        cap[i] <= cap_next[i];
      end
      macs <= macs_next;
      key  <= key_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && last_byte) begin
      port_out     <= key_next.port;
      eth_dst      <= key_next.dst;
      eth_src      <= key_next.src;
      ether_type   <= key_next.etype;
      vlan_word    <= {key_next.pcp, key_next.vid};
      mpls_word    <= {key_next.tc, key_next.label};
      ip_src       <= key_next.nsrc;
      ip_dst       <= key_next.ndst;
      proto_tos    <= {key_next.proto, key_next.tos};
      l4_ports     <= {key_next.tpsrc, key_next.tpdst};
      present_bits <= key_next.present;
    end
  end

endmodule
`default_nettype wire
